### src/gda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_pkg
// Shared types, widths, function codes and calendar tables for the
// Gregorian date arithmetic unit.
// ----------------------------------------------------------------------------
package gda_pkg;

  // Default upper year bound
  localparam int unsigned MAX_YEAR_DEF = 9999;

  // Internal widths (sized for the largest allowed year bound)
  localparam int YW  = 19;  // signed working year
  localparam int CW  = 26;  // day number of one date
  localparam int NW  = 27;  // signed sum or difference of day numbers
  localparam int YMW = 16;  // year reduced toward mod 400

  // Function codes
  localparam logic [2:0] FN_NORM       = 3'd0;
  localparam logic [2:0] FN_TO_COUNT   = 3'd1;
  localparam logic [2:0] FN_FROM_COUNT = 3'd2;
  localparam logic [2:0] FN_ADD_DATES  = 3'd3;
  localparam logic [2:0] FN_ADD_OFF    = 3'd4;
  localparam logic [2:0] FN_DIFF       = 3'd5;
  localparam logic [2:0] FN_CMP        = 3'd6;

  // Datapath commands
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_WRAP,
    CMD_MOD_INIT,
    CMD_MOD_STEP,
    CMD_ROLL,
    CMD_SAT,
    CMD_P_INIT,
    CMD_DIV400,
    CMD_STORE_A,
    CMD_STORE_B,
    CMD_OP,
    CMD_FC_INIT,
    CMD_Q400,
    CMD_Q100,
    CMD_Q4,
    CMD_Q1,
    CMD_YEAR,
    CMD_MON,
    CMD_FSAT,
    CMD_FINISH
  } cmd_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic wrap_done;
    logic mod_done;
    logic roll_done;
    logic div_done;
    logic has_fc;
    logic zero_count;
    logic q400_done;
    logic q100_done;
    logic q4_done;
    logic q1_done;
    logic mon_done;
  } status_t;

  // Days in a month
  function automatic logic [4:0] month_days(input logic leap, input logic [3:0] m);
    logic [4:0] n;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      4'd2:                    n = leap ? 5'd29 : 5'd28;
      default:                 n = 5'd31;
    endcase
    return n;
  endfunction

  // Days in the months before m of a common year
  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // Leap status from the year mod 400
  function automatic logic leap_of(input logic [8:0] ym);
    return (ym[1:0] == 2'd0) && (ym != 9'd100) && (ym != 9'd200) && (ym != 9'd300);
  endfunction

endpackage

### src/gda_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_datapath
// Working registers for date normalization, day-number conversion in both
// directions, and the result register. Driven one command per cycle.
// ----------------------------------------------------------------------------
module gda_datapath #(
  parameter int unsigned MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
  input  logic                clk,
  input  gda_pkg::cmd_t       cmd,
  output gda_pkg::status_t    status,
  input  logic [2:0]          func,
  input  logic signed [10:0]  day_a,
  input  logic signed [8:0]   month_a,
  input  logic [13:0]         year_a,
  input  logic [4:0]          day_b,
  input  logic [3:0]          month_b,
  input  logic [13:0]         year_b,
  input  logic signed [22:0]  offset_days,
  output logic [4:0]          res_day,
  output logic [3:0]          res_month,
  output logic [13:0]         res_year,
  output logic [21:0]         day_count,
  output logic                a_greater,
  output logic                range_error
);
  import gda_pkg::*;

  localparam logic signed [YW-1:0] YONE     = YW'(1);
  localparam logic signed [YW-1:0] YMAX     = YW'(MAX_YEAR);
  localparam logic [8:0]           YMAX_MOD = 9'(MAX_YEAR % 400);

  // Captured request
  logic [2:0]         func_q;
  logic signed [10:0] day_a_q;
  logic signed [8:0]  month_a_q;
  logic [13:0]        year_a_q;
  logic [4:0]         day_b_q;
  logic [3:0]         month_b_q;
  logic [13:0]        year_b_q;
  logic signed [22:0] off_q;

  // Working registers
  logic [10:0]         d;
  logic signed [9:0]   m;
  logic signed [YW-1:0] y;
  logic [YMW-1:0]      ym;
  logic [NW-1:0]       r;
  logic [8:0]          q;
  logic [1:0]          q100;
  logic [4:0]          q4;
  logic [1:0]          q1;
  logic                fl;
  logic                err;
  logic [CW-1:0]       ca;
  logic [CW-1:0]       cb;
  logic [4:0]          ad, bd;
  logic [3:0]          am, bm;
  logic signed [YW-1:0] ay, by;

  // Combinational helpers
  logic               leap_n;
  logic [4:0]         ml;
  logic [4:0]         mlf;
  logic [15:0]        p;
  logic [1:0]         q100c;
  logic [CW-1:0]      cnt;
  logic signed [NW-1:0] ca_s, cb_s, off_s, nsum, nabs;
  logic [YW-1:0]      yr_fc;
  logic               gt;

  // Result next values
  logic [4:0]         res_day_next;
  logic [3:0]         res_month_next;
  logic [13:0]        res_year_next;
  logic [21:0]        day_count_next;
  logic               a_greater_next;
  logic               range_error_next;

  assign leap_n = leap_of(ym[8:0]);
  assign ml     = month_days(leap_n, m[3:0]);
  assign mlf    = month_days(fl, m[3:0]);
  assign p      = 16'(y - YONE);

  // Centuries left in p mod 400
  always_comb begin
    if (r >= NW'(300))      q100c = 2'd3;
    else if (r >= NW'(200)) q100c = 2'd2;
    else if (r >= NW'(100)) q100c = 2'd1;
    else                    q100c = 2'd0;
  end

  // Day number of the normalized date in d/m/y
  assign cnt = CW'(p) * CW'(365) + CW'(p[15:2]) - CW'({q, 2'b00}) - CW'(q100c)
             + CW'(q) + CW'(days_before(m[3:0])) + CW'(leap_n && (m > 10'sd2)) + CW'(d);

  // Day number operand selection
  assign ca_s  = $signed({1'b0, ca});
  assign cb_s  = $signed({1'b0, cb});
  assign off_s = {{(NW-23){off_q[22]}}, off_q};
  always_comb begin
    case (func_q)
      FN_FROM_COUNT: nsum = off_s;
      FN_ADD_DATES:  nsum = ca_s + cb_s;
      FN_ADD_OFF:    nsum = ca_s + off_s;
      default:       nsum = ca_s - cb_s;
    endcase
  end
  assign nabs = nsum[NW-1] ? -nsum : nsum;

  // Year from the cycle counts
  assign yr_fc = YW'(q) * YW'(400) + YW'(q100) * YW'(100) + YW'({q4, 2'b00})
               + YW'(q1) + YW'(1);

  // Date comparison
  always_comb begin
    if (ay != by)      gt = ay > by;
    else if (am != bm) gt = am > bm;
    else               gt = ad > bd;
  end

  // Result selection by function
  always_comb begin
    res_day_next     = '0;
    res_month_next   = '0;
    res_year_next    = '0;
    day_count_next   = '0;
    a_greater_next   = 1'b0;
    range_error_next = err;
    case (func_q)
      FN_NORM: begin
        res_day_next   = ad;
        res_month_next = am;
        res_year_next  = ay[13:0];
      end
      FN_TO_COUNT: day_count_next = ca[21:0];
      FN_CMP:      a_greater_next = gt;
      FN_FROM_COUNT, FN_ADD_DATES, FN_ADD_OFF, FN_DIFF: begin
        res_day_next   = d[4:0];
        res_month_next = m[3:0];
        res_year_next  = y[13:0];
      end
      default: range_error_next = 1'b0;
    endcase
  end

  // Status
  always_comb begin
    status.wrap_done  = (m >= 10'sd1) && (m <= 10'sd12);
    status.mod_done   = ym < YMW'(400);
    status.roll_done  = d <= 11'(ml);
    status.div_done   = r < NW'(400);
    status.has_fc     = (func_q == FN_FROM_COUNT) || (func_q == FN_ADD_DATES) ||
                        (func_q == FN_ADD_OFF) || (func_q == FN_DIFF);
    status.zero_count = r == '0;
    status.q400_done  = r < NW'(146097);
    status.q100_done  = (r < NW'(36524)) || (q100 == 2'd3);
    status.q4_done    = r < NW'(1461);
    status.q1_done    = (r < NW'(365)) || (q1 == 2'd3);
    status.mon_done   = (m == 10'sd12) || (d <= 11'(mlf));
  end

  // Register updates per command
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_CAPTURE: begin
        func_q    <= func;
        day_a_q   <= day_a;
        month_a_q <= month_a;
        year_a_q  <= year_a;
        day_b_q   <= day_b;
        month_b_q <= month_b;
        year_b_q  <= year_b;
        off_q     <= offset_days;
        err       <= 1'b0;
      end
      CMD_LOAD_A: begin
        d <= day_a_q[10] ? 11'(-day_a_q) : 11'(day_a_q);
        m <= 10'(month_a_q);
        y <= $signed(YW'(year_a_q));
      end
      CMD_LOAD_B: begin
        d <= 11'(day_b_q);
        m <= $signed(10'(month_b_q));
        y <= $signed(YW'(year_b_q));
      end
      CMD_WRAP: begin
        if (m < 10'sd1) begin
          m <= m + 10'sd12;
          y <= y - YONE;
        end else if (m > 10'sd12) begin
          m <= m - 10'sd12;
          y <= y + YONE;
        end
      end
      CMD_MOD_INIT: begin
        ym <= (y < 0) ? YMW'(y + YW'(400)) : YMW'(y);
      end
      CMD_MOD_STEP: begin
        if (ym >= YMW'(400)) ym <= ym - YMW'(400);
      end
      CMD_ROLL: begin
        if (d > 11'(ml)) begin
          d <= d - 11'(ml);
          if (m == 10'sd12) begin
            m  <= 10'sd1;
            y  <= y + YONE;
            ym <= (ym == YMW'(399)) ? '0 : ym + YMW'(1);
          end else begin
            m <= m + 10'sd1;
          end
        end
      end
      CMD_SAT: begin
        if (y < YONE) begin
          d   <= 11'd1;
          m   <= 10'sd1;
          y   <= YONE;
          ym  <= YMW'(1);
          err <= 1'b1;
        end else if (y > YMAX) begin
          d   <= 11'd31;
          m   <= 10'sd12;
          y   <= YMAX;
          ym  <= YMW'(YMAX_MOD);
          err <= 1'b1;
        end
      end
      CMD_P_INIT: begin
        r <= NW'(p);
        q <= '0;
      end
      CMD_DIV400: begin
        if (r >= NW'(400)) begin
          r <= r - NW'(400);
          q <= q + 9'd1;
        end
      end
      CMD_STORE_A: begin
        ca <= cnt;
        ad <= d[4:0];
        am <= m[3:0];
        ay <= y;
      end
      CMD_STORE_B: begin
        cb <= cnt;
        bd <= d[4:0];
        bm <= m[3:0];
        by <= y;
      end
      CMD_OP: begin
        r <= NW'(nabs);
      end
      CMD_FC_INIT: begin
        if (r == '0) begin
          d <= '0;
          m <= 10'sd1;
          y <= YONE;
        end else begin
          r    <= r - NW'(1);
          q    <= '0;
          q100 <= '0;
          q4   <= '0;
          q1   <= '0;
        end
      end
      CMD_Q400: begin
        if (r >= NW'(146097)) begin
          r <= r - NW'(146097);
          q <= q + 9'd1;
        end
      end
      CMD_Q100: begin
        if ((r >= NW'(36524)) && (q100 != 2'd3)) begin
          r    <= r - NW'(36524);
          q100 <= q100 + 2'd1;
        end
      end
      CMD_Q4: begin
        if (r >= NW'(1461)) begin
          r  <= r - NW'(1461);
          q4 <= q4 + 5'd1;
        end
      end
      CMD_Q1: begin
        if ((r >= NW'(365)) && (q1 != 2'd3)) begin
          r  <= r - NW'(365);
          q1 <= q1 + 2'd1;
        end
      end
      CMD_YEAR: begin
        y  <= $signed(yr_fc);
        d  <= 11'(r) + 11'd1;
        m  <= 10'sd1;
        fl <= (q1 == 2'd3) && ((q4 != 5'd24) || (q100 == 2'd3));
      end
      CMD_MON: begin
        if ((m != 10'sd12) && (d > 11'(mlf))) begin
          d <= d - 11'(mlf);
          m <= m + 10'sd1;
        end
      end
      CMD_FSAT: begin
        if (y > YMAX) begin
          d   <= 11'd31;
          m   <= 10'sd12;
          y   <= YMAX;
          err <= 1'b1;
        end
      end
      CMD_FINISH: begin
        res_day     <= res_day_next;
        res_month   <= res_month_next;
        res_year    <= res_year_next;
        day_count   <= day_count_next;
        a_greater   <= a_greater_next;
        range_error <= range_error_next;
      end
      default: ;
    endcase
  end

endmodule

### src/gda_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_ctrl
// Sequencer: normalizes date A then date B, converts each to a day number,
// runs the day-number-to-date steps when the function needs them, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module gda_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  gda_pkg::status_t  status,
  output gda_pkg::cmd_t     cmd
);
  import gda_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_WRAP, S_MOD_INIT, S_MOD, S_ROLL, S_SAT, S_P_INIT,
    S_DIV, S_STORE, S_OP, S_FC_INIT, S_Q400, S_Q100, S_Q4, S_Q1, S_YEAR,
    S_MON, S_FSAT, S_DONE
  } state_t;

  state_t state;
  logic   pass_b;
  logic   out_free;

  assign in_stall = state != S_IDLE;
  assign out_free = !out_valid || !out_stall;

  // Command decode
  always_comb begin
    unique case (state)
      S_IDLE:     cmd = in_valid ? CMD_CAPTURE : CMD_NONE;
      S_LOAD:     cmd = pass_b ? CMD_LOAD_B : CMD_LOAD_A;
      S_WRAP:     cmd = CMD_WRAP;
      S_MOD_INIT: cmd = CMD_MOD_INIT;
      S_MOD:      cmd = CMD_MOD_STEP;
      S_ROLL:     cmd = CMD_ROLL;
      S_SAT:      cmd = CMD_SAT;
      S_P_INIT:   cmd = CMD_P_INIT;
      S_DIV:      cmd = CMD_DIV400;
      S_STORE:    cmd = pass_b ? CMD_STORE_B : CMD_STORE_A;
      S_OP:       cmd = CMD_OP;
      S_FC_INIT:  cmd = CMD_FC_INIT;
      S_Q400:     cmd = CMD_Q400;
      S_Q100:     cmd = CMD_Q100;
      S_Q4:       cmd = CMD_Q4;
      S_Q1:       cmd = CMD_Q1;
      S_YEAR:     cmd = CMD_YEAR;
      S_MON:      cmd = CMD_MON;
      S_FSAT:     cmd = CMD_FSAT;
      S_DONE:     cmd = out_free ? CMD_FINISH : CMD_NONE;
      default:    cmd = CMD_NONE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pass_b    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && out_free) out_valid <= 1'b1;
      else if (out_valid && !out_stall)  out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) begin
          pass_b <= 1'b0;
          state  <= S_LOAD;
        end
        S_LOAD:     state <= S_WRAP;
        S_WRAP:     if (status.wrap_done) state <= S_MOD_INIT;
        S_MOD_INIT: state <= S_MOD;
        S_MOD:      if (status.mod_done) state <= S_ROLL;
        S_ROLL:     if (status.roll_done) state <= S_SAT;
        S_SAT:      state <= S_P_INIT;
        S_P_INIT:   state <= S_DIV;
        S_DIV:      if (status.div_done) state <= S_STORE;
        S_STORE: begin
          if (!pass_b) begin
            pass_b <= 1'b1;
            state  <= S_LOAD;
          end else if (status.has_fc) begin
            state <= S_OP;
          end else begin
            state <= S_DONE;
          end
        end
        S_OP:       state <= S_FC_INIT;
        S_FC_INIT:  state <= status.zero_count ? S_DONE : S_Q400;
        S_Q400:     if (status.q400_done) state <= S_Q100;
        S_Q100:     if (status.q100_done) state <= S_Q4;
        S_Q4:       if (status.q4_done) state <= S_Q1;
        S_Q1:       if (status.q1_done) state <= S_YEAR;
        S_YEAR:     state <= S_MON;
        S_MON:      if (status.mon_done) state <= S_FSAT;
        S_FSAT:     state <= S_DONE;
        S_DONE:     if (out_free) state <= S_IDLE;
        default:    state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/gregorian_date_arithmetic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic
// Proleptic Gregorian date unit: normalize, date to day number, day number
// to date, date sums and differences, and date compare.
// Throughput: one request at a time; the next is taken once the result is written.
// The time from accept to result valid, plus any wait of the finished
// result for the output register, is set by the subtract-and-count loops
// of the datapath: month
// wrap, year mod 400 and 400-year division per date, then the 400/100/4/1
// year cycle and month loops of the day-number-to-date conversion.
// A new request is taken while a finished result waits in the output register.
// Reset (rst, synchronous) clears the sequencer and the output valid only.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic #(
  parameter int unsigned MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         func,
  input  logic signed [10:0] day_a,
  input  logic signed [8:0]  month_a,
  input  logic [13:0]        year_a,
  input  logic [4:0]         day_b,
  input  logic [3:0]         month_b,
  input  logic [13:0]        year_b,
  input  logic signed [22:0] offset_days,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         res_day,
  output logic [3:0]         res_month,
  output logic [13:0]        res_year,
  output logic [21:0]        day_count,
  output logic               a_greater,
  output logic               range_error
);
  import gda_pkg::*;

  cmd_t    cmd;
  status_t status;

  gda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  gda_datapath #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .status      (status),
    .func        (func),
    .day_a       (day_a),
    .month_a     (month_a),
    .year_a      (year_a),
    .day_b       (day_b),
    .month_b     (month_b),
    .year_b      (year_b),
    .offset_days (offset_days),
    .res_day     (res_day),
    .res_month   (res_month),
    .res_year    (res_year),
    .day_count   (day_count),
    .a_greater   (a_greater),
    .range_error (range_error)
  );

endmodule

### src/gda_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_checker
// Port-level checks for the date unit, bound to the top level.
// ----------------------------------------------------------------------------
module gda_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [4:0]         res_day,
  input logic [3:0]         res_month,
  input logic [13:0]        res_year,
  input logic [21:0]        day_count,
  input logic               a_greater,
  input logic               range_error
);

  // A held result stays valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped while stalled");

  // A held result does not change
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(res_day) && $stable(res_month) &&
    $stable(res_year) && $stable(day_count) && $stable(a_greater) &&
    $stable(range_error)) else $error("result changed while stalled");

  // The unit is busy right after taking a request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("second request taken while busy");

  // A date result has a month in 1..12 and a nonzero year
  a_date_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (res_month != 4'd0) |-> (res_month <= 4'd12) && (res_year != 14'd0))
    else $error("malformed date result");

  // A compare result carries no date and no day number
  a_cmp_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && a_greater |-> (res_month == 4'd0) && (day_count == 22'd0))
    else $error("compare result mixed with other fields");

endmodule

bind gregorian_date_arithmetic gda_checker u_gda_checker (.*);
